@@ rtl/polar_point_stabilizer_defines.svh @@
// Assertion macros used by the checker file of the stabiliser.
`ifndef POLAR_POINT_STABILIZER_DEFINES_SVH
`define POLAR_POINT_STABILIZER_DEFINES_SVH

`define PPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pps_pkg.sv @@
package pps_pkg;

  localparam int unsigned SQRT_STEPS = 20;
  localparam int unsigned XY_W       = 31;
  localparam int unsigned ANG_W      = 20;
  localparam int unsigned RAD_W      = 40;
  localparam int unsigned REM_W      = 22;
  localparam int unsigned ROOT_W     = 20;

  localparam logic signed [ANG_W-1:0] PI_Q      = 20'sd205887;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q  = 20'sd411775;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q = 20'sd102944;

  localparam logic [15:0] GAIN_ALPHA_RST = 16'd9830;
  localparam logic [15:0] GAIN_BETA_RST  = 16'd131;
  localparam logic [15:0] GAIN_RHO_RST   = 16'd6554;
  localparam logic [15:0] HALF_AXLE_RST  = 16'd4325;
  localparam logic [23:0] WHEEL_GAIN_RST = 24'd67446;

  typedef enum logic [2:0] {
    CFG_GAIN_ALPHA = 3'd0,
    CFG_GAIN_BETA  = 3'd1,
    CFG_GAIN_RHO   = 3'd2,
    CFG_HALF_AXLE  = 3'd3,
    CFG_WHEEL_GAIN = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] gain_alpha;
    logic [15:0] gain_beta;
    logic [15:0] gain_rho;
    logic [15:0] half_axle;
    logic [23:0] wheel_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  xa;
    logic signed [XY_W-1:0]  ya;
    logic signed [XY_W-1:0]  xb;
    logic signed [XY_W-1:0]  yb;
    logic signed [ANG_W-1:0] za;
    logic signed [ANG_W-1:0] zb;
    logic                    zero;
    logic [RAD_W-1:0]        rad;
    logic [REM_W-1:0]        rem;
    logic [ROOT_W-1:0]       root;
    logic signed [15:0]      heading;
    logic signed [15:0]      target;
    logic                    rev;
  } iter_t;

  function automatic logic [15:0] atan_q16(input int unsigned step);
    unique case (step)
      0:       return 16'd51472;
      1:       return 16'd30386;
      2:       return 16'd16055;
      3:       return 16'd8150;
      4:       return 16'd4091;
      5:       return 16'd2047;
      6:       return 16'd1024;
      7:       return 16'd512;
      8:       return 16'd256;
      9:       return 16'd128;
      10:      return 16'd64;
      11:      return 16'd32;
      12:      return 16'd16;
      13:      return 16'd8;
      14:      return 16'd4;
      15:      return 16'd2;
      16:      return 16'd1;
      default: return 16'd0;
    endcase
  endfunction

endpackage

@@ rtl/pps_front.sv @@
module pps_front import pps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  logic signed [15:0] error_x_i,
  input  logic signed [15:0] error_y_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [15:0] target_heading_i,
  input  logic               reverse_i,
  output logic               valid_o,
  output iter_t              data_o
);

  logic               valid_q;
  iter_t              data_d;
  iter_t              data_q;
  logic signed [16:0] ex, ey, nx, ny;
  logic signed [XY_W-1:0] xa0, ya0, xb0, yb0;
  logic signed [31:0] px, py;
  logic [31:0]        sq;

  always_comb begin
    ex  = {error_x_i[15], error_x_i};
    ey  = {error_y_i[15], error_y_i};
    nx  = -ex;
    ny  = -ey;
    xa0 = XY_W'(nx) <<< 12;
    ya0 = XY_W'(ny) <<< 12;
    xb0 = XY_W'(ex) <<< 12;
    yb0 = XY_W'(ey) <<< 12;
    px  = error_x_i * error_x_i;
    py  = error_y_i * error_y_i;
    sq  = $unsigned(px) + $unsigned(py);

    data_d.xa = xa0;
    data_d.ya = ya0;
    data_d.za = '0;
    if (xa0[XY_W-1]) begin
      data_d.za = ya0[XY_W-1] ? -PI_Q : PI_Q;
      data_d.xa = -xa0;
      data_d.ya = -ya0;
    end
    data_d.xb = xb0;
    data_d.yb = yb0;
    data_d.zb = '0;
    if (xb0[XY_W-1]) begin
      data_d.zb = yb0[XY_W-1] ? -PI_Q : PI_Q;
      data_d.xb = -xb0;
      data_d.yb = -yb0;
    end
    data_d.zero    = (error_x_i == 16'sd0) && (error_y_i == 16'sd0);
    data_d.rad     = {sq, 8'b0};
    data_d.rem     = '0;
    data_d.root    = '0;
    data_d.heading = heading_i;
    data_d.target  = target_heading_i;
    data_d.rev     = reverse_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/pps_iter.sv @@
module pps_iter import pps_pkg::*; #(
  parameter int STEP         = 0,
  parameter int CORDIC_STEPS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  valid_i,
  input  iter_t data_i,
  output logic  valid_o,
  output iter_t data_o
);

  localparam bit DO_CORDIC = (STEP < CORDIC_STEPS);
  localparam bit DO_SQRT   = (STEP < int'(SQRT_STEPS));

  logic             valid_q;
  iter_t            data_d;
  iter_t            data_q;
  logic [REM_W+1:0] acc;
  logic [REM_W+1:0] trial;
  logic signed [ANG_W-1:0] dz;

  always_comb begin
    data_d = data_i;
    dz     = $signed(ANG_W'(atan_q16(STEP)));
    acc    = {data_i.rem, data_i.rad[RAD_W-1 -: 2]};
    trial  = {2'b00, data_i.root, 2'b01};
    if (DO_CORDIC) begin
      if (!data_i.ya[XY_W-1]) begin
        data_d.xa = data_i.xa + (data_i.ya >>> STEP);
        data_d.ya = data_i.ya - (data_i.xa >>> STEP);
        data_d.za = data_i.za + dz;
      end else begin
        data_d.xa = data_i.xa - (data_i.ya >>> STEP);
        data_d.ya = data_i.ya + (data_i.xa >>> STEP);
        data_d.za = data_i.za - dz;
      end
      if (!data_i.yb[XY_W-1]) begin
        data_d.xb = data_i.xb + (data_i.yb >>> STEP);
        data_d.yb = data_i.yb - (data_i.xb >>> STEP);
        data_d.zb = data_i.zb + dz;
      end else begin
        data_d.xb = data_i.xb - (data_i.yb >>> STEP);
        data_d.yb = data_i.yb + (data_i.xb >>> STEP);
        data_d.zb = data_i.zb - dz;
      end
    end
    if (DO_SQRT) begin
      data_d.rad = {data_i.rad[RAD_W-3:0], 2'b00};
      if (acc >= trial) begin
        data_d.rem  = REM_W'(acc - trial);
        data_d.root = {data_i.root[ROOT_W-2:0], 1'b1};
      end else begin
        data_d.rem  = REM_W'(acc);
        data_d.root = {data_i.root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/pps_back.sv @@
module pps_back import pps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  iter_t              data_i,
  input  cfg_t               cfg_i,
  output logic               valid_o,
  output logic signed [7:0]  right_cmd_o,
  output logic signed [7:0]  left_cmd_o,
  output logic               right_clipped_o,
  output logic               left_clipped_o,
  output logic [15:0]        distance_o,
  output logic signed [16:0] bearing_error_o
);

  typedef struct packed {
    logic signed [ANG_W-1:0] alpha;
    logic signed [15:0]      heading;
    logic signed [15:0]      target;
    logic [ROOT_W-1:0]       rho;
    logic                    rev;
  } sa_t;

  typedef struct packed {
    logic signed [36:0]      pa;
    logic signed [38:0]      pb;
    logic [35:0]             pv;
    logic signed [ANG_W-1:0] alpha;
    logic [ROOT_W-1:0]       rho;
    logic                    rev;
  } sb_t;

  typedef struct packed {
    logic signed [39:0]      w;
    logic signed [36:0]      v;
    logic signed [ANG_W-1:0] alpha;
    logic [ROOT_W-1:0]       rho;
  } sc_t;

  typedef struct packed {
    logic signed [56:0]      lw;
    logic signed [36:0]      v;
    logic signed [ANG_W-1:0] alpha;
    logic [ROOT_W-1:0]       rho;
  } sd_t;

  typedef struct packed {
    logic [56:0]             mr;
    logic [56:0]             ml;
    logic                    negr;
    logic                    negl;
    logic signed [ANG_W-1:0] alpha;
    logic [ROOT_W-1:0]       rho;
  } se_t;

  typedef struct packed {
    logic [52:0]             phr;
    logic [51:0]             plr;
    logic [52:0]             phl;
    logic [51:0]             pll;
    logic                    negr;
    logic                    negl;
    logic signed [ANG_W-1:0] alpha;
    logic [ROOT_W-1:0]       rho;
  } sf_t;

  function automatic logic signed [ANG_W-1:0] wrap_ang(input logic signed [ANG_W-1:0] z);
    priority if (z >= PI_Q) begin
      return z - TWO_PI_Q;
    end else if (z < -PI_Q) begin
      return z + TWO_PI_Q;
    end else begin
      return z;
    end
  endfunction

  function automatic logic [8:0] wheel_out(input logic [52:0] ph, input logic [51:0] pl,
                                          input logic neg);
    logic [53:0] sum;
    logic [25:0] mag;
    logic [7:0]  cmd;
    logic        clip;
    sum  = 54'(ph) + 54'(pl >> 28);
    mag  = 26'(sum >> 28);
    clip = (mag >= 26'd127);
    cmd  = clip ? 8'd127 : mag[7:0];
    if (neg) begin
      cmd = -cmd;
    end
    return {clip, cmd};
  endfunction

  logic va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vo_q;
  sa_t  sa_d, sa_q;
  sb_t  sb_d, sb_q;
  sc_t  sc_d, sc_q;
  sd_t  sd_d, sd_q;
  se_t  se_d, se_q;
  sf_t  sf_d, sf_q;

  logic signed [ANG_W-1:0] wa, wb, tha, a1;
  logic signed [21:0]      thb, thd, bt;
  logic signed [56:0]      vs;
  logic signed [57:0]      sr, sl;
  logic [8:0]              wr, wl;
  logic signed [7:0]       right_cmd_q, left_cmd_q;
  logic                    right_clipped_q, left_clipped_q;
  logic [15:0]             distance_q;
  logic signed [16:0]      bearing_error_q;

  always_comb begin
    wa  = data_i.zero ? '0 : wrap_ang(data_i.za);
    wb  = data_i.zero ? '0 : wrap_ang(data_i.zb);
    tha = ANG_W'(data_i.heading) <<< 3;
    a1  = wa - tha;
    sa_d.alpha = a1;
    if (a1 >= HALF_PI_Q || a1 <= -HALF_PI_Q) begin
      sa_d.alpha = wb - tha;
    end
    sa_d.heading = data_i.heading;
    sa_d.target  = data_i.target;
    sa_d.rho     = data_i.root;
    sa_d.rev     = data_i.rev;
  end

  always_comb begin
    thb = 22'(sa_q.heading) <<< 3;
    thd = 22'(sa_q.target) <<< 3;
    bt  = thd - thb - 22'(sa_q.alpha);
    sb_d.pa    = $signed({1'b0, cfg_i.gain_alpha}) * sa_q.alpha;
    sb_d.pb    = $signed({1'b0, cfg_i.gain_beta}) * bt;
    sb_d.pv    = cfg_i.gain_rho * sa_q.rho;
    sb_d.alpha = sa_q.alpha;
    sb_d.rho   = sa_q.rho;
    sb_d.rev   = sa_q.rev;
  end

  always_comb begin
    sc_d.w     = 40'(sb_q.pa) - 40'(sb_q.pb);
    sc_d.v     = sb_q.rev ? -$signed({1'b0, sb_q.pv}) : $signed({1'b0, sb_q.pv});
    sc_d.alpha = sb_q.alpha;
    sc_d.rho   = sb_q.rho;
  end

  always_comb begin
    sd_d.lw    = $signed({1'b0, cfg_i.half_axle}) * sc_q.w;
    sd_d.v     = sc_q.v;
    sd_d.alpha = sc_q.alpha;
    sd_d.rho   = sc_q.rho;
  end

  always_comb begin
    vs = 57'(sd_q.v) <<< 16;
    sr = 58'(vs) + 58'(sd_q.lw);
    sl = 58'(vs) - 58'(sd_q.lw);
    se_d.negr  = sr[57];
    se_d.negl  = sl[57];
    se_d.mr    = 57'(sr[57] ? -sr : sr);
    se_d.ml    = 57'(sl[57] ? -sl : sl);
    se_d.alpha = sd_q.alpha;
    se_d.rho   = sd_q.rho;
  end

  always_comb begin
    sf_d.phr   = se_q.mr[56:28] * cfg_i.wheel_gain;
    sf_d.plr   = se_q.mr[27:0] * cfg_i.wheel_gain;
    sf_d.phl   = se_q.ml[56:28] * cfg_i.wheel_gain;
    sf_d.pll   = se_q.ml[27:0] * cfg_i.wheel_gain;
    sf_d.negr  = se_q.negr;
    sf_d.negl  = se_q.negl;
    sf_d.alpha = se_q.alpha;
    sf_d.rho   = se_q.rho;
  end

  always_comb begin
    wr = wheel_out(sf_q.phr, sf_q.plr, sf_q.negr);
    wl = wheel_out(sf_q.phl, sf_q.pll, sf_q.negl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
      vo_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sa_q            <= sa_d;
      sb_q            <= sb_d;
      sc_q            <= sc_d;
      sd_q            <= sd_d;
      se_q            <= se_d;
      sf_q            <= sf_d;
      right_cmd_q     <= $signed(wr[7:0]);
      left_cmd_q      <= $signed(wl[7:0]);
      right_clipped_q <= wr[8];
      left_clipped_q  <= wl[8];
      distance_q      <= 16'(sf_q.rho >> 4);
      bearing_error_q <= 17'(sf_q.alpha >>> 3);
    end
  end

  assign valid_o         = vo_q;
  assign right_cmd_o     = right_cmd_q;
  assign left_cmd_o      = left_cmd_q;
  assign right_clipped_o = right_clipped_q;
  assign left_clipped_o  = left_clipped_q;
  assign distance_o      = distance_q;
  assign bearing_error_o = bearing_error_q;

endmodule

@@ rtl/polar_point_stabilizer.sv @@
// Polar-coordinate pose controller for a differential-drive robot. Each transfer of a
// position error, heading, target heading and drive direction yields one transfer of
// two saturated wheel commands with clip flags, the distance to the goal and the
// bearing error. The block is a pipeline that takes one item per clock cycle while
// the output is not stalled: a front register, a chain of CORDIC and square-root
// iteration stages (one atan2 step for each of two vectors and one root bit per stage),
// then seven stages of angle selection, gain multiplication and wheel scaling. A stall
// on the output holds the whole pipeline in place. The user must write gains through
// the configuration port only while no item is in flight; the block does not check it.
module polar_point_stabilizer import pps_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] error_x_i,
  input  logic signed [15:0] error_y_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [15:0] target_heading_i,
  input  logic               reverse_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [7:0]  right_cmd_o,
  output logic signed [7:0]  left_cmd_o,
  output logic               right_clipped_o,
  output logic               left_clipped_o,
  output logic [15:0]        distance_o,
  output logic signed [16:0] bearing_error_o
);

  localparam int NIT = (CORDIC_STEPS > int'(SQRT_STEPS)) ? CORDIC_STEPS : int'(SQRT_STEPS);

  cfg_t  cfg_q;
  logic  adv;
  logic  valid_s [NIT+1];
  iter_t data_s  [NIT+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_alpha <= GAIN_ALPHA_RST;
      cfg_q.gain_beta  <= GAIN_BETA_RST;
      cfg_q.gain_rho   <= GAIN_RHO_RST;
      cfg_q.half_axle  <= HALF_AXLE_RST;
      cfg_q.wheel_gain <= WHEEL_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_GAIN_ALPHA: cfg_q.gain_alpha <= cfg_wdata_i[15:0];
        CFG_GAIN_BETA:  cfg_q.gain_beta  <= cfg_wdata_i[15:0];
        CFG_GAIN_RHO:   cfg_q.gain_rho   <= cfg_wdata_i[15:0];
        CFG_HALF_AXLE:  cfg_q.half_axle  <= cfg_wdata_i[15:0];
        CFG_WHEEL_GAIN: cfg_q.wheel_gain <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  pps_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .adv_i            (adv),
    .valid_i          (in_valid_i),
    .error_x_i        (error_x_i),
    .error_y_i        (error_y_i),
    .heading_i        (heading_i),
    .target_heading_i (target_heading_i),
    .reverse_i        (reverse_i),
    .valid_o          (valid_s[0]),
    .data_o           (data_s[0])
  );

  for (genvar k = 0; k < NIT; k++) begin : g_iter
    pps_iter #(
      .STEP         (k),
      .CORDIC_STEPS (CORDIC_STEPS)
    ) u_iter (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (valid_s[k]),
      .data_i  (data_s[k]),
      .valid_o (valid_s[k+1]),
      .data_o  (data_s[k+1])
    );
  end

  pps_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .valid_i         (valid_s[NIT]),
    .data_i          (data_s[NIT]),
    .cfg_i           (cfg_q),
    .valid_o         (out_valid_o),
    .right_cmd_o     (right_cmd_o),
    .left_cmd_o      (left_cmd_o),
    .right_clipped_o (right_clipped_o),
    .left_clipped_o  (left_clipped_o),
    .distance_o      (distance_o),
    .bearing_error_o (bearing_error_o)
  );

endmodule

@@ rtl/pps_checker.sv @@
`include "polar_point_stabilizer_defines.svh"

module pps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [7:0]  right_cmd_o,
  input logic signed [7:0]  left_cmd_o,
  input logic               right_clipped_o,
  input logic               left_clipped_o
);

  `PPS_ASSERT_NOW(a_cmd_range, out_valid_o,
    right_cmd_o != 8'sh80 && left_cmd_o != 8'sh80, "wheel command outside range")
  `PPS_ASSERT_NOW(a_clip_mag, out_valid_o && (right_clipped_o || left_clipped_o),
    (!right_clipped_o || right_cmd_o == 8'sd127 || right_cmd_o == -8'sd127) &&
    (!left_clipped_o || left_cmd_o == 8'sd127 || left_cmd_o == -8'sd127),
    "clip flag without full-scale command")
  `PPS_ASSERT_NOW(a_backpressure, out_valid_o && out_stall_i, in_stall_o,
    "input taken while the output transfer is stalled")
  `PPS_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o,
    "stalled result dropped")

endmodule

bind polar_point_stabilizer pps_checker u_checker (.*);

@@ tb/sv/tb_top.sv @@
module tb_top;
  import pps_pkg::*;

  localparam int          STEPS      = 16;
  localparam longint      PI_R       = 205887;
  localparam longint      TWO_PI_R   = 411775;
  localparam longint      HALF_PI_R  = 102944;
  localparam int          LATENCY    = 28;
  localparam logic [2:0]  CFG_SPARE  = 3'd5;
  localparam logic [2:0]  CFG_TOP    = 3'd7;

  typedef struct {
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic signed [15:0] hd;
    logic signed [15:0] tg;
    logic               rev;
  } pose_t;

  typedef struct {
    logic signed [7:0]  rcmd;
    logic signed [7:0]  lcmd;
    logic               rclip;
    logic               lclip;
    logic [15:0]        reach;
    logic signed [16:0] bear;
  } drive_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [23:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] error_x_i = '0;
  logic signed [15:0] error_y_i = '0;
  logic signed [15:0] heading_i = '0;
  logic signed [15:0] target_heading_i = '0;
  logic reverse_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [7:0] right_cmd_o, left_cmd_o;
  logic right_clipped_o, left_clipped_o;
  logic [15:0] distance_o;
  logic signed [16:0] bearing_error_o;

  polar_point_stabilizer u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .error_x_i, .error_y_i, .heading_i,
    .target_heading_i, .reverse_i, .out_valid_o, .out_stall_i,
    .right_cmd_o, .left_cmd_o, .right_clipped_o, .left_clipped_o,
    .distance_o, .bearing_error_o
  );

  always #2 clk_i = ~clk_i;

  longint unsigned k_alpha, k_beta, k_rho, k_axle, k_wheel;
  pose_t  pose_q[$];
  drive_t drive_q[$];
  int     mismatches = 0;
  bit     took = 0;
  bit     idle_on = 1;
  bit     hold_req = 0;
  int     hold_cnt = 0;

  function automatic longint angle_of(longint y, longint x);
    longint tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2, 1};
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 4096;
    y = y * 4096;
    if (x < 0) begin
      z = (y >= 0) ? PI_R : -PI_R;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + tab[i];
      end else begin
        x = x - ys; y = y + xs; z = z - tab[i];
      end
    end
    while (z >= PI_R) z = z - TWO_PI_R;
    while (z < -PI_R) z = z + TWO_PI_R;
    return z;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [8:0] wheel_cmd(longint s);
    longint unsigned m, mh, ml, mag;
    logic clip;
    m = (s < 0) ? longint'(-s) : longint'(s);
    mh = m >> 28;
    ml = m & 64'h0FFF_FFFF;
    mag = (mh * k_wheel + ((ml * k_wheel) >> 28)) >> 28;
    clip = 1'b0;
    if (mag >= 127) begin
      mag = 127;
      clip = 1'b1;
    end
    if (s < 0) mag = -mag;
    return {clip, mag[7:0]};
  endfunction

  function automatic drive_t steer(pose_t p);
    drive_t d;
    longint dx, dy, th, thd, rho, alpha, beta, w, v, lw;
    logic [8:0] r, l;
    longint unsigned sq;
    dx = p.ex;
    dy = p.ey;
    th = longint'(p.hd) * 8;
    thd = longint'(p.tg) * 8;
    sq = dx * dx + dy * dy;
    rho = root_floor(sq << 8);
    alpha = angle_of(-dy, -dx) - th;
    if (alpha >= HALF_PI_R || alpha <= -HALF_PI_R) alpha = angle_of(dy, dx) - th;
    beta = -th - alpha;
    w = longint'(k_alpha) * alpha - longint'(k_beta) * (beta + thd);
    v = longint'(k_rho) * rho;
    if (p.rev) v = -v;
    v = v * 65536;
    lw = longint'(k_axle) * w;
    r = wheel_cmd(v + lw);
    l = wheel_cmd(v - lw);
    d.rcmd = r[7:0];
    d.rclip = r[8];
    d.lcmd = l[7:0];
    d.lclip = l[8];
    d.reach = 16'(rho >>> 4);
    d.bear = 17'(alpha >>> 3);
    return d;
  endfunction

  function automatic logic signed [15:0] pick16(bit narrow);
    if (narrow) return 16'($signed($urandom_range(8192)) - 4096);
    return 16'($urandom);
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    bit narrow;
    narrow = ($urandom_range(99) < 60);
    p.ex = pick16(narrow);
    p.ey = pick16(narrow);
    p.hd = ($urandom_range(99) < 60) ? pick16(1'b1) * 4 : pick16(1'b0);
    p.tg = ($urandom_range(99) < 60) ? pick16(1'b1) * 4 : pick16(1'b0);
    p.rev = 1'($urandom_range(1));
    if ($urandom_range(99) < 5) begin
      p.ex = 0;
      p.ey = 0;
    end
    return p;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GAIN_ALPHA: k_alpha = val[15:0];
      CFG_GAIN_BETA:  k_beta = val[15:0];
      CFG_GAIN_RHO:   k_rho = val[15:0];
      CFG_HALF_AXLE:  k_axle = val[15:0];
      CFG_WHEEL_GAIN: k_wheel = val;
      default: ;
    endcase
  endtask

  task automatic load_gains(logic [23:0] a, logic [23:0] b, logic [23:0] r,
                            logic [23:0] h, logic [23:0] g);
    write_reg(CFG_GAIN_ALPHA, a);
    write_reg(CFG_GAIN_BETA, b);
    write_reg(CFG_GAIN_RHO, r);
    write_reg(CFG_HALF_AXLE, h);
    write_reg(CFG_WHEEL_GAIN, g);
    write_reg(($urandom_range(1) != 0) ? CFG_SPARE : CFG_TOP, 24'($urandom));
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pose_q.size() != 0 || (in_valid_i && !took) || drive_q.size() != 0);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic push(logic signed [15:0] ex, logic signed [15:0] ey,
                      logic signed [15:0] hd, logic signed [15:0] tg, logic rev);
    pose_t p;
    p.ex = ex; p.ey = ey; p.hd = hd; p.tg = tg; p.rev = rev;
    pose_q = {pose_q, p};
  endtask

  task automatic push_random(int n);
    repeat (n) pose_q = {pose_q, random_pose()};
  endtask

  always @(posedge clk_i) begin
    pose_t p;
    drive_t e;
    took = in_valid_i && !in_stall_o;
    if (took) begin
      p.ex = error_x_i; p.ey = error_y_i; p.hd = heading_i;
      p.tg = target_heading_i; p.rev = reverse_i;
      drive_q = {drive_q, steer(p)};
    end
    if (out_valid_o && !out_stall_i) begin
      if (drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
      end else begin
        e = drive_q.pop_front();
        if (e.rcmd !== right_cmd_o || e.lcmd !== left_cmd_o ||
            e.rclip !== right_clipped_o || e.lclip !== left_clipped_o ||
            e.reach !== distance_o || e.bear !== bearing_error_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d %0d %0b %0b %0d %0d got %0d %0d %0b %0b %0d %0d",
                     e.rcmd, e.lcmd, e.rclip, e.lclip, e.reach, e.bear,
                     right_cmd_o, left_cmd_o, right_clipped_o, left_clipped_o,
                     distance_o, bearing_error_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    pose_t p;
    if (rst_ni && (!in_valid_i || took)) begin
      if (pose_q.size() != 0 && !(idle_on && $urandom_range(99) < 6)) begin
        p = pose_q.pop_front();
        error_x_i <= p.ex;
        error_y_i <= p.ey;
        heading_i <= p.hd;
        target_heading_i <= p.tg;
        reverse_i <= p.rev;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_cnt = 300;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      out_stall_i <= 1'b1;
      hold_cnt--;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(99) < 6);
    end
  end

  initial begin
    k_alpha = GAIN_ALPHA_RST;
    k_beta = GAIN_BETA_RST;
    k_rho = GAIN_RHO_RST;
    k_axle = HALF_AXLE_RST;
    k_wheel = WHEEL_GAIN_RST;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    push(0, 0, 0, 0, 0);
    push(0, 0, 16'sh7fff, 16'sh8000, 1);
    push(16'sh7fff, 16'sh7fff, 0, 0, 0);
    push(16'sh8000, 16'sh8000, 0, 0, 1);
    push(16'sh8000, 0, 0, 0, 0);
    push(16'sh7fff, 0, 0, 0, 1);
    push(0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    push(0, 16'sh8000, 16'sh8000, 16'sh8000, 1);
    push(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 0);
    push(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1);
    push(-4096, 1, 0, 0, 0);
    push(-4096, -1, 0, 0, 0);
    push(4096, 0, 12868, 0, 0);
    push(4096, 0, -12868, 0, 1);
    push(-16'sd1, 0, 0, 0, 0);
    push(0, -16'sd1, 0, 0, 1);
    push(410, 300, 800, -800, 0);
    push(-410, 300, -800, 800, 1);
    push_random(150);
    drain();

    load_gains(24'hffff, 24'hffff, 24'hffff, 24'hffff, 24'hffffff);
    push(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1);
    push(1, 0, 0, 0, 0);
    push_random(100);
    drain();

    load_gains(0, 0, 0, 0, 0);
    push(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    push_random(60);
    drain();

    load_gains(24'($urandom_range(65535)), 24'($urandom_range(65535)),
               24'($urandom_range(65535)), 24'($urandom_range(65535)),
               24'($urandom));
    idle_on = 0;
    hold_req = 1;
    push_random(250);
    drain();
    idle_on = 1;

    load_gains(24'($urandom_range(2000)), 24'($urandom_range(500)),
               24'($urandom_range(2000)), 24'($urandom_range(65535)),
               24'($urandom_range(100000)));
    push_random(270);
    drain();

    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pps_pkg.sv
rtl/pps_front.sv
rtl/pps_iter.sv
rtl/pps_back.sv
rtl/polar_point_stabilizer.sv
rtl/pps_checker.sv
tb/sv/tb_top.sv
